@@ hw/rtl/swe_pkg.sv @@
`default_nettype none

package swe_pkg;

    // Field widths
    localparam int LETTER_W   = 8;
    localparam int ENERGY_W   = 4;
    localparam int WSIZE_W    = 7;
    localparam int OUT_W      = 10;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_G    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_T    = 3'd4;

    // Nucleotide characters (upper case ASCII)
    localparam logic [LETTER_W-1:0] CHAR_A = 8'h41;
    localparam logic [LETTER_W-1:0] CHAR_C = 8'h43;
    localparam logic [LETTER_W-1:0] CHAR_G = 8'h47;
    localparam logic [LETTER_W-1:0] CHAR_T = 8'h54;

    typedef logic signed [ENERGY_W-1:0] energy_t;

    // Register reset values
    localparam logic [WSIZE_W-1:0] WIN_LEN_RST = 7'd5;
    localparam energy_t ENERGY_A_RST = -4'sd1;
    localparam energy_t ENERGY_C_RST = 4'sd1;
    localparam energy_t ENERGY_G_RST = 4'sd1;
    localparam energy_t ENERGY_T_RST = -4'sd1;

    // Control carried alongside an item from the front stage to the accumulator
    typedef struct packed {
        logic start;   // sum restarts from zero
        logic sub;     // oldest energy leaves the window
        logic emit;    // window full, a result goes out
    } stage_ctl_t;

    // Character to energy; anything other than A, C, G, T scores zero
    function automatic energy_t letter_energy(
        input logic [LETTER_W-1:0] letter,
        input energy_t             ea,
        input energy_t             ec,
        input energy_t             eg,
        input energy_t             et
    );
        energy_t e;
        begin
            case (letter)
                CHAR_A:  e = ea;
                CHAR_C:  e = ec;
                CHAR_G:  e = eg;
                CHAR_T:  e = et;
                default: e = '0;
            endcase
            return e;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/swe_front.sv @@
`default_nettype none

// Front stage: energy lookup, window bookkeeping and the energy ring.
// The ring is written and the leaving entry read at the accepting edge.
module swe_front #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [swe_pkg::WSIZE_W-1:0]       win_len,
    input  wire swe_pkg::energy_t                  energy_a,
    input  wire swe_pkg::energy_t                  energy_c,
    input  wire swe_pkg::energy_t                  energy_g,
    input  wire swe_pkg::energy_t                  energy_t,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [swe_pkg::LETTER_W-1:0]      letter,
    input  wire logic                              start_of_sequence,
    output logic                                   s1_valid,
    output swe_pkg::stage_ctl_t                    s1_ctl,
    output swe_pkg::energy_t                       s1_code,
    output swe_pkg::energy_t                       s1_old,
    input  wire logic                              s1_ready
);

    localparam int AW_W  = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int ADR_W = AW_W + 1;
    localparam int CMP_W = (AW_W > swe_pkg::WSIZE_W) ? AW_W : swe_pkg::WSIZE_W;
    localparam int RST_WIN = (MAX_WINDOW < 5) ? MAX_WINDOW : 5;

    localparam logic [AW_W-1:0]  WIN_MAX  = AW_W'(MAX_WINDOW);
    localparam logic [AW_W-1:0]  WIN_RST  = AW_W'(RST_WIN);
    localparam logic [CMP_W-1:0] WIN_LIM  = CMP_W'(MAX_WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);
    localparam logic [ADR_W-1:0] RING_LEN = ADR_W'(MAX_WINDOW);

    swe_pkg::energy_t ring [MAX_WINDOW];

    logic [PTR_W-1:0] wp_reg, wp_next, wp_eff;
    logic [AW_W-1:0]  fill_reg, fill_next, fill_eff;
    logic [AW_W-1:0]  active_reg, aw_eff, win_clamped;
    logic [CMP_W-1:0] ws_ext;
    logic [ADR_W-1:0] old_sum, old_wrap;
    logic [PTR_W-1:0] old_idx;
    logic             sub, emit, accept;
    swe_pkg::energy_t code;
    logic                s1_valid_reg;
    swe_pkg::stage_ctl_t ctl_reg;
    swe_pkg::energy_t    code_reg, old_reg;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // Window size latched at a start: zero counts as one, large values clip
    always_comb
    begin
        ws_ext = CMP_W'(win_len);
        if (ws_ext == '0)
            win_clamped = AW_W'(1);
        else if (ws_ext > WIN_LIM)
            win_clamped = WIN_MAX;
        else
            win_clamped = AW_W'(ws_ext);
    end

    // Pointer, fill and leaving-entry address for the incoming character
    always_comb
    begin
        code      = swe_pkg::letter_energy(letter, energy_a, energy_c, energy_g, energy_t);
        aw_eff    = start_of_sequence ? win_clamped : active_reg;
        wp_eff    = start_of_sequence ? '0 : wp_reg;
        fill_eff  = start_of_sequence ? '0 : fill_reg;
        sub       = (fill_eff >= aw_eff);
        fill_next = sub ? fill_eff : fill_eff + 1'b1;
        emit      = (fill_next >= aw_eff);
        wp_next   = (wp_eff == PTR_LAST) ? '0 : wp_eff + 1'b1;
        old_sum   = ADR_W'(wp_eff) + RING_LEN - ADR_W'(aw_eff);
        old_wrap  = (old_sum >= RING_LEN) ? old_sum - RING_LEN : old_sum;
        old_idx   = old_wrap[PTR_W-1:0];
    end

    // Ring write and leaving-entry read (read returns the value before the write)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring[wp_eff] <= code;
            old_reg      <= ring[old_idx];
            code_reg     <= code;
        end
    end

    // Window state and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            fill_reg     <= '0;
            active_reg   <= WIN_RST;
            s1_valid_reg <= 1'b0;
            ctl_reg      <= '0;
        end
        else if (accept)
        begin
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            active_reg    <= aw_eff;
            s1_valid_reg  <= 1'b1;
            ctl_reg.start <= start_of_sequence;
            ctl_reg.sub   <= sub;
            ctl_reg.emit  <= emit;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = ctl_reg;
    assign s1_code  = code_reg;
    assign s1_old   = old_reg;

endmodule

`default_nettype wire

@@ hw/rtl/swe_accum.sv @@
`default_nettype none

// Accumulator stage: running sum update, saturation and the result register.
module swe_accum #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s1_valid,
    input  wire swe_pkg::stage_ctl_t            s1_ctl,
    input  wire swe_pkg::energy_t               s1_code,
    input  wire swe_pkg::energy_t               s1_old,
    output logic                                s1_ready,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [swe_pkg::OUT_W-1:0]    window_energy
);

    localparam int SUM_RAW = $clog2(8 * MAX_WINDOW) + 1;
    localparam int SUM_W   = (SUM_RAW > swe_pkg::OUT_W) ? SUM_RAW : swe_pkg::OUT_W;

    localparam logic signed [SUM_W-1:0] OUT_HI = SUM_W'(511);
    localparam logic signed [SUM_W-1:0] OUT_LO = -SUM_W'(512);

    logic signed [SUM_W-1:0]         sum_reg, sum_next, sum_base, add_val, sub_val;
    logic signed [swe_pkg::OUT_W-1:0] sat_val;
    logic signed [swe_pkg::OUT_W-1:0] out_reg;
    logic                             out_valid_reg;
    logic                             advance;

    assign s1_ready = !out_valid_reg || out_ready;
    assign advance  = s1_valid && s1_ready;

    // New sum: entering energy in, leaving energy out
    always_comb
    begin
        sum_base = s1_ctl.start ? '0 : sum_reg;
        add_val  = SUM_W'(s1_code);
        sub_val  = s1_ctl.sub ? SUM_W'(s1_old) : '0;
        sum_next = sum_base + add_val - sub_val;
        if (sum_next > OUT_HI)
            sat_val = swe_pkg::OUT_W'(OUT_HI);
        else if (sum_next < OUT_LO)
            sat_val = swe_pkg::OUT_W'(OUT_LO);
        else
            sat_val = sum_next[swe_pkg::OUT_W-1:0];
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= sat_val;
    end

    // Sum and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_reg       <= sum_next;
            out_valid_reg <= s1_ctl.emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_energy = out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sequence_window_energy.sv @@
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: letter[7:0]; tuser: start_of_sequence
// m_        out  m_tvalid/m_tready  tdata: window_energy[9:0], zeros above
// cfg_      in   cfg_we             cfg_index selects register, cfg_data value
//
// One character per cycle sustained while m_tready is high; a result shows on m_
// after its transaction passes the ring read register and the result register.
// Reset clears the window as if a start with window size 5 had happened.
// A stalled result holds the accumulator stage, which in turn stalls s_.
// The ring needs no clearing: only entries written since the last start are read.
module sequence_window_energy #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [swe_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] letter
    input  wire logic                               s_tuser,   // [0] start_of_sequence
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [swe_pkg::OUT_TDATA_W-1:0]         m_tdata,   // [9:0] window_energy
    input  wire logic                               cfg_we,
    input  wire logic [swe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [swe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [swe_pkg::WSIZE_W-1:0]      win_len_reg;
    swe_pkg::energy_t                 energy_a_reg, energy_c_reg, energy_g_reg, energy_t_reg;
    logic                             s1_valid, s1_ready;
    swe_pkg::stage_ctl_t              s1_ctl;
    swe_pkg::energy_t                 s1_code, s1_old;
    logic signed [swe_pkg::OUT_W-1:0] window_energy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg     <= swe_pkg::WIN_LEN_RST;
            energy_a_reg    <= swe_pkg::ENERGY_A_RST;
            energy_c_reg    <= swe_pkg::ENERGY_C_RST;
            energy_g_reg    <= swe_pkg::ENERGY_G_RST;
            energy_t_reg    <= swe_pkg::ENERGY_T_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swe_pkg::REG_WIN_LEN:     win_len_reg  <= cfg_data[swe_pkg::WSIZE_W-1:0];
                swe_pkg::REG_ENERGY_A:    energy_a_reg <= cfg_data[swe_pkg::ENERGY_W-1:0];
                swe_pkg::REG_ENERGY_C:    energy_c_reg <= cfg_data[swe_pkg::ENERGY_W-1:0];
                swe_pkg::REG_ENERGY_G:    energy_g_reg <= cfg_data[swe_pkg::ENERGY_W-1:0];
                swe_pkg::REG_ENERGY_T:    energy_t_reg <= cfg_data[swe_pkg::ENERGY_W-1:0];
                default:                  ;
            endcase
        end
    end

    swe_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .win_len           (win_len_reg),
        .energy_a          (energy_a_reg),
        .energy_c          (energy_c_reg),
        .energy_g          (energy_g_reg),
        .energy_t          (energy_t_reg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .letter            (s_tdata[swe_pkg::LETTER_W-1:0]),
        .start_of_sequence (s_tuser),
        .s1_valid          (s1_valid),
        .s1_ctl            (s1_ctl),
        .s1_code           (s1_code),
        .s1_old            (s1_old),
        .s1_ready          (s1_ready)
    );

    swe_accum #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_ctl        (s1_ctl),
        .s1_code       (s1_code),
        .s1_old        (s1_old),
        .s1_ready      (s1_ready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .window_energy (window_energy)
    );

    // Result padded with zeros to whole bytes
    assign m_tdata = {{(swe_pkg::OUT_TDATA_W - swe_pkg::OUT_W){1'b0}}, window_energy};

endmodule

`default_nettype wire

@@ hw/rtl/swe_checker.sv @@
`default_nettype none

// Port-level checks on the result channel
module swe_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [swe_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Padding bits above the energy stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[swe_pkg::OUT_TDATA_W-1:swe_pkg::OUT_W] == '0))
        else $error("padding bits set in result");

    // A fresh result follows an earlier input transaction
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transaction");

endmodule

bind sequence_window_energy swe_checker u_swe_checker (.*);

`default_nettype wire
